### sv/mvsa_pkg.sv
`default_nettype none

package mvsa_pkg;

    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int MAX_ITEMS_DEF     = 65536;
    localparam int FRACTION_BITS_DEF = 8;

    localparam int MEAN_W  = 24;
    localparam int VAR_W   = 40;
    localparam int STD_W   = 24;
    localparam int COUNT_W = 17;
    localparam int ERR_W   = 2;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic REG_SAMPLE_MODE = 1'b0;

    localparam logic [ERR_W-1:0] ERR_OK  = 2'd0;
    localparam logic [ERR_W-1:0] ERR_ONE = 2'd1;
    localparam logic [ERR_W-1:0] ERR_OVF = 2'd2;

    typedef enum logic [2:0] {
        OP_SS   = 3'd0,
        OP_NQ   = 3'd1,
        OP_DEN  = 3'd2,
        OP_MEAN = 3'd3,
        OP_VAR  = 3'd4,
        OP_SQRT = 3'd5
    } op_t;

    typedef struct packed {
        logic accept;
        logic start;
        op_t  op;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic             done;
        logic             out_busy;
        logic [ERR_W-1:0] err;
    } status_t;

endpackage

`default_nettype wire

### sv/mvsa_ctrl.sv
`default_nettype none

module mvsa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              last,
    output logic              in_ready,
    input  mvsa_pkg::status_t status,
    output mvsa_pkg::cmd_t    cmd
);
    import mvsa_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CHECK = 9'b000000010,
        S_SS    = 9'b000000100,
        S_NQ    = 9'b000001000,
        S_DEN   = 9'b000010000,
        S_MEAN  = 9'b000100000,
        S_VAR   = 9'b001000000,
        S_SQRT  = 9'b010000000,
        S_EMIT  = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.op     = OP_SS;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (last)
                        state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.err != ERR_OK)
                    state_next = S_EMIT;
                else
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_SS;
                    state_next = S_SS;
                end
            end
            S_SS:
            begin
                if (status.done)
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_NQ;
                    state_next = S_NQ;
                end
            end
            S_NQ:
            begin
                if (status.done)
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_DEN;
                    state_next = S_DEN;
                end
            end
            S_DEN:
            begin
                if (status.done)
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_MEAN;
                    state_next = S_MEAN;
                end
            end
            S_MEAN:
            begin
                if (status.done)
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_VAR;
                    state_next = S_VAR;
                end
            end
            S_VAR:
            begin
                if (status.done)
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_SQRT;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (status.done)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // hold until the output register is free
                if (!status.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

### sv/mvsa_dp.sv
`default_nettype none

module mvsa_dp #(
    parameter int SAMPLE_BITS   = mvsa_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_ITEMS     = mvsa_pkg::MAX_ITEMS_DEF,
    parameter int FRACTION_BITS = mvsa_pkg::FRACTION_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mvsa_pkg::cmd_t                      cmd,
    output mvsa_pkg::status_t                   status,
    input  logic                                sample_mode,
    input  logic signed [SAMPLE_BITS-1:0]       sample,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic signed [mvsa_pkg::MEAN_W-1:0]  mean_q8,
    output logic [mvsa_pkg::VAR_W-1:0]          variance_q8,
    output logic [mvsa_pkg::STD_W-1:0]          stddev_q8,
    output logic [mvsa_pkg::COUNT_W-1:0]        item_count,
    output logic [mvsa_pkg::ERR_W-1:0]          error_code
);
    import mvsa_pkg::*;

    localparam int CW  = $clog2(MAX_ITEMS + 1);
    localparam int SW  = SAMPLE_BITS + CW;
    localparam int QW  = 2 * SAMPLE_BITS - 2 + CW;
    localparam int MW  = SAMPLE_BITS + CW - 1;
    localparam int NW  = 2 * MW;
    localparam int DNW = 2 * CW;
    localparam int DW  = NW + 2 * FRACTION_BITS;
    localparam int SQW = DW + (DW % 2);
    localparam int HW  = SQW / 2;
    localparam int STW = $clog2(DW);

    // set accumulators
    logic [CW-1:0]        cnt_reg;
    logic signed [SW-1:0] sum_reg;
    logic [QW-1:0]        sq_reg;
    logic                 ovf_reg;

    // sequencing of the shared iterative engine
    logic           busy_reg;
    logic           done_reg;
    op_t            op_reg;
    logic [STW-1:0] step_reg;
    logic [STW-1:0] op_steps;

    // engine registers
    logic [NW-1:0]  prod_reg;
    logic [NW-1:0]  mcand_reg;
    logic [MW-1:0]  mplier_reg;
    logic [DW-1:0]  quo_reg;
    logic [DNW-1:0] drem_reg;
    logic [DNW-1:0] divisor_reg;
    logic [SQW-1:0] src_reg;
    logic [HW+1:0]  srem_reg;
    logic [HW-1:0]  root_reg;

    // finished intermediate results
    logic [NW-1:0]  ss_reg;
    logic [NW-1:0]  nq_reg;
    logic [DNW-1:0] den_reg;
    logic [DW-1:0]  mean_reg;
    logic [DW-1:0]  y_reg;

    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] ax;
    logic [2*SAMPLE_BITS-1:0] x2;
    logic                   sum_neg;
    logic [MW-1:0]          mag;
    logic [NW-1:0]          num;
    logic [DNW:0]           dcand;
    logic                   div_ge;
    logic [HW+3:0]          scand;
    logic [HW+3:0]          strial;
    logic                   sq_ge;
    logic [ERR_W-1:0]       err;

    assign ax      = sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample) : SAMPLE_BITS'(sample);
    assign x2      = ax * ax;
    assign sum_neg = sum_reg[SW-1];
    assign mag     = sum_neg ? MW'(-sum_reg) : MW'(sum_reg);
    assign num     = (nq_reg >= ss_reg) ? (nq_reg - ss_reg) : '0;

    assign dcand  = {drem_reg, quo_reg[DW-1]};
    assign div_ge = (dcand >= {1'b0, divisor_reg});
    assign scand  = {srem_reg, src_reg[SQW-1 -: 2]};
    assign strial = (HW+4)'({root_reg, 2'b01});
    assign sq_ge  = (scand >= strial);

    assign err = ovf_reg ? ERR_OVF
               : ((sample_mode && (cnt_reg < CW'(2))) ? ERR_ONE : ERR_OK);

    assign status.done     = done_reg;
    assign status.out_busy = out_valid_reg && !out_ready;
    assign status.err      = err;
    assign out_valid       = out_valid_reg;

    always_comb
    begin
        case (cmd.op)
            OP_SS, OP_NQ, OP_DEN: op_steps = STW'(MW - 1);
            OP_MEAN, OP_VAR:      op_steps = STW'(DW - 1);
            OP_SQRT:              op_steps = STW'(HW - 1);
            default:              op_steps = STW'(DW - 1);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            sum_reg <= '0;
            sq_reg  <= '0;
            ovf_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            cnt_reg <= '0;
            sum_reg <= '0;
            sq_reg  <= '0;
            ovf_reg <= 1'b0;
        end
        else if (cmd.accept)
        begin
            // drop samples beyond the maximum set length
            if (cnt_reg == CW'(MAX_ITEMS))
                ovf_reg <= 1'b1;
            else
            begin
                cnt_reg <= cnt_reg + CW'(1);
                sum_reg <= sum_reg + SW'(sample);
                sq_reg  <= sq_reg + QW'(x2);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_SS;
            step_reg <= '0;
        end
        else if (cmd.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            op_reg   <= cmd.op;
            step_reg <= op_steps;
        end
        else if (busy_reg)
        begin
            if (step_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
                step_reg <= step_reg - STW'(1);
        end
        else
            done_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            case (cmd.op)
                OP_SS:
                begin
                    prod_reg   <= '0;
                    mcand_reg  <= NW'(mag);
                    mplier_reg <= mag;
                end
                OP_NQ:
                begin
                    prod_reg   <= '0;
                    mcand_reg  <= NW'(sq_reg);
                    mplier_reg <= MW'(cnt_reg);
                end
                OP_DEN:
                begin
                    prod_reg   <= '0;
                    mcand_reg  <= NW'(cnt_reg);
                    mplier_reg <= MW'(sample_mode ? (cnt_reg - CW'(1)) : cnt_reg);
                end
                OP_MEAN:
                begin
                    drem_reg    <= '0;
                    divisor_reg <= DNW'(cnt_reg);
                    quo_reg     <= DW'(mag) << FRACTION_BITS;
                end
                OP_VAR:
                begin
                    drem_reg    <= '0;
                    divisor_reg <= den_reg;
                    quo_reg     <= DW'(num) << (2 * FRACTION_BITS);
                end
                OP_SQRT:
                begin
                    src_reg  <= SQW'(quo_reg);
                    srem_reg <= '0;
                    root_reg <= '0;
                end
                default:
                begin
                    prod_reg <= '0;
                end
            endcase
        end
        else if (busy_reg)
        begin
            case (op_reg)
                OP_SS, OP_NQ, OP_DEN:
                begin
                    if (mplier_reg[0])
                        prod_reg <= prod_reg + mcand_reg;
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                end
                OP_MEAN, OP_VAR:
                begin
                    drem_reg <= DNW'(div_ge ? (dcand - {1'b0, divisor_reg}) : dcand);
                    quo_reg  <= {quo_reg[DW-2:0], div_ge};
                end
                OP_SQRT:
                begin
                    srem_reg <= (HW+2)'(sq_ge ? (scand - strial) : scand);
                    root_reg <= {root_reg[HW-2:0], sq_ge};
                    src_reg  <= src_reg << 2;
                end
                default:
                begin
                    prod_reg <= prod_reg;
                end
            endcase
        end
    end

    // capture each finished multiply and divide result the cycle after its last step
    always_ff @(posedge clk)
    begin
        if (done_reg)
        begin
            case (op_reg)
                OP_SS:   ss_reg   <= prod_reg;
                OP_NQ:   nq_reg   <= prod_reg;
                OP_DEN:  den_reg  <= DNW'(prod_reg);
                OP_MEAN: mean_reg <= quo_reg;
                OP_VAR:  y_reg    <= quo_reg;
                default: y_reg    <= y_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            item_count <= COUNT_W'(cnt_reg);
            error_code <= err;
            if (err != ERR_OK)
            begin
                mean_q8     <= '0;
                variance_q8 <= '0;
                stddev_q8   <= '0;
            end
            else
            begin
                mean_q8     <= MEAN_W'(sum_neg ? (-mean_reg) : mean_reg);
                variance_q8 <= VAR_W'(y_reg >> FRACTION_BITS);
                stddev_q8   <= STD_W'(root_reg);
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_ITEMS))
        else $error("set count beyond maximum");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !busy_reg)
        else $error("engine started while busy");
    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid_reg)
        else $error("result not presented after emit");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("done held longer than one cycle");
`endif

endmodule

`default_nettype wire

### sv/mean_variance_stddev_accumulator.sv
// Running mean / variance / standard deviation over sets of signed samples.
// Input channel (in_valid/in_ready): one sample per transfer, last closes
// the set. Samples of a set are taken one per cycle. After the transfer that
// carries last, the block stops taking samples while it computes. The steps of
// the shared iterative engine each take their iteration count plus a hand-off:
//   three shift-add multiplies of SAMPLE_BITS+CW-1 iterations each,
//   two restoring divides of DW = 2*(SAMPLE_BITS+CW-1)+2*FRACTION_BITS,
//   one square root of DW/2 iterations, plus a check and an emit step,
// where CW = clog2(MAX_ITEMS+1). out_valid and in_ready rise together as the
// emit step ends, so the first sample of the next set can be taken at once.
// Output channel (out_valid/out_ready): one result per set, held in an
// output register; samples of the next set are taken while it waits. If the
// previous result is still not taken when a new one is ready, the block
// holds in its emit step until out_ready, and the input stays closed.
// Configuration: APB register sample_mode at address 0 (0 divides by n,
// 1 by n-1); write it only while idle.
// Reset clears the accumulators, the output valid and sample_mode.
`default_nettype none

module mean_variance_stddev_accumulator #(
    parameter int SAMPLE_BITS   = mvsa_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_ITEMS     = mvsa_pkg::MAX_ITEMS_DEF,
    parameter int FRACTION_BITS = mvsa_pkg::FRACTION_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mvsa_pkg::ADDR_W-1:0]         paddr,
    input  logic [mvsa_pkg::DATA_W-1:0]         pwdata,
    output logic [mvsa_pkg::DATA_W-1:0]         prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [SAMPLE_BITS-1:0]       sample,
    input  logic                                last,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [mvsa_pkg::MEAN_W-1:0]  mean_q8,
    output logic [mvsa_pkg::VAR_W-1:0]          variance_q8,
    output logic [mvsa_pkg::STD_W-1:0]          stddev_q8,
    output logic [mvsa_pkg::COUNT_W-1:0]        item_count,
    output logic [mvsa_pkg::ERR_W-1:0]          error_code
);
    import mvsa_pkg::*;

    logic    mode_reg;
    logic    sel_mode;
    cmd_t    cmd;
    status_t status;

    assign pready   = 1'b1;
    assign sel_mode = (paddr[2] == REG_SAMPLE_MODE);
    assign prdata   = sel_mode ? DATA_W'(mode_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b0;
        else if (psel && penable && pwrite && sel_mode)
            mode_reg <= pwdata[0];
    end

    mvsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .last     (last),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    mvsa_dp #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .MAX_ITEMS     (MAX_ITEMS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .sample_mode (mode_reg),
        .sample      (sample),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .mean_q8     (mean_q8),
        .variance_q8 (variance_q8),
        .stddev_q8   (stddev_q8),
        .item_count  (item_count),
        .error_code  (error_code)
    );

endmodule

`default_nettype wire
